FILE: design/aip_pkg.sv
// Types, codes and constants shared by the ASCII integer parser.
`timescale 1ns / 1ps

package aip_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned CONS_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned PROD_W   = VALUE_W + RADIX_W + 1;

  localparam logic [VALUE_W-1:0] SMAX     = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SMAX_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] UMAX     = {VALUE_W{1'b1}};

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] NO_DIGIT    = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = BASE_DEC;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_SIGNED;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_XSEEN  = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e               phase;
    logic [VALUE_W-1:0]   acc;
    logic                 neg;
    logic                 ovf;
    logic [RADIX_W-1:0]   wbase;
  } parse_state_t;

  typedef struct packed {
    logic                 emit;
    logic [VALUE_W-1:0]   value;
    logic [CONS_W-1:0]    consumed;
    logic [STATUS_W-1:0]  status;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_LEAD, acc: '0, neg: 1'b0, ovf: 1'b0, wbase: '0
  };

  function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [RADIX_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = RADIX_W'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = RADIX_W'(c - CH_LO_A) + BASE_DEC;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = RADIX_W'(c - CH_UP_A) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

FILE: design/aip_if.sv
// Channel interfaces: character input, parse result and configuration write.
`timescale 1ns / 1ps

interface aip_ch_if import aip_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface aip_res_if import aip_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [CONS_W-1:0]   consumed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output value, output consumed, output status,
                  input ready);
  modport sink   (input valid, input value, input consumed, input status,
                  output ready);
endinterface

interface aip_cfg_if import aip_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/aip_step.sv
// Per-character parse step: next string state and optional result.
`timescale 1ns / 1ps

module aip_step import aip_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic [CH_W-1:0]       ch_i,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  parse_state_t          st_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  output parse_state_t          st_o,
  output logic [COUNT_BITS-1:0] cnt_o,
  output parse_result_t         res_o
);

  localparam int unsigned CW = (COUNT_BITS > CONS_W) ? COUNT_BITS : CONS_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [RADIX_W-1:0]    digit;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [RADIX_W-1:0]    fc_base;
  logic                  radix_bad;
  logic [RADIX_W-1:0]    acc_base;
  logic [RADIX_W-1:0]    base_eff;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_W-1:0]    limit;
  logic                  range_mode;
  logic                  acc_ovf;
  logic                  ws;
  logic                  do_first;
  logic                  do_acc;
  logic                  do_finish;
  logic [COUNT_BITS-1:0] emit_cnt;
  logic [CW-1:0]         emit_ext;
  parse_state_t          st_d;
  logic [COUNT_BITS-1:0] cnt_d;
  parse_result_t         res;

  assign digit     = digit_of(ch_i);
  assign cnt_inc   = (cnt_i == CNT_MAX) ? cnt_i : cnt_i + COUNT_BITS'(1);
  assign fc_base   = (radix_i == RADIX_AUTO) ? BASE_DEC : radix_i;
  assign radix_bad = (radix_i != RADIX_AUTO) &&
                     ((radix_i < RADIX_MIN) || (radix_i > RADIX_MAX));
  assign ws        = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));

  always_comb begin
    if (st_i.phase == PH_XSEEN) begin
      acc_base = BASE_HEX;
    end else if (st_i.phase == PH_LEAD || st_i.phase == PH_FIRST) begin
      acc_base = fc_base;
    end else begin
      acc_base = st_i.wbase;
    end
  end

  assign base_eff   = (acc_base < RADIX_MIN) ? RADIX_MIN : acc_base;
  assign prod       = PROD_W'(st_i.acc) * PROD_W'(base_eff) + PROD_W'(digit);
  assign range_mode = (mode_i == MODE_SIGNED) || (mode_i == MODE_UNSIGNED);
  assign limit      = (mode_i == MODE_UNSIGNED) ? UMAX : (st_i.neg ? SMAX_NEG : SMAX);
  assign acc_ovf    = range_mode && (prod > PROD_W'(limit));

  always_comb begin
    st_d      = st_i;
    cnt_d     = cnt_i;
    res       = '0;
    do_first  = 1'b0;
    do_acc    = 1'b0;
    do_finish = 1'b0;
    emit_cnt  = cnt_i;

    unique case (st_i.phase)
      PH_LEAD: begin
        if (ws) begin
          cnt_d = cnt_inc;
        end else if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
          st_d.neg   = (ch_i == CH_MINUS);
          st_d.phase = PH_FIRST;
          cnt_d      = cnt_inc;
        end else begin
          do_first = 1'b1;
        end
      end
      PH_FIRST: begin
        do_first = 1'b1;
      end
      PH_ZERO: begin
        if (ch_i == CH_LO_X || ch_i == CH_UP_X) begin
          st_d.phase = PH_XSEEN;
          cnt_d      = cnt_inc;
        end else begin
          st_d.phase = PH_DIGITS;
          if (digit < st_i.wbase) begin
            do_acc = 1'b1;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      PH_XSEEN: begin
        if (digit < BASE_HEX) begin
          st_d.wbase = BASE_HEX;
          st_d.phase = PH_DIGITS;
          do_acc     = 1'b1;
        end else begin
          res.emit   = 1'b1;
          res.status = ST_OK;
          emit_cnt   = (cnt_i == '0) ? '0 : cnt_i - COUNT_BITS'(1);
        end
      end
      PH_DIGITS: begin
        if (digit < st_i.wbase) begin
          do_acc = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end
      default: begin
        st_d = st_i;
      end
    endcase

    if (do_first) begin
      if (radix_bad) begin
        res.emit   = 1'b1;
        res.status = ST_INVALID;
        emit_cnt   = '0;
      end else if (ch_i == CH_ZERO &&
                   (radix_i == RADIX_AUTO || radix_i == BASE_HEX)) begin
        st_d.wbase = (radix_i == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
        st_d.acc   = '0;
        st_d.phase = PH_ZERO;
        cnt_d      = cnt_inc;
      end else if (digit < fc_base) begin
        st_d.wbase = fc_base;
        st_d.phase = PH_DIGITS;
        do_acc     = 1'b1;
      end else begin
        res.emit   = 1'b1;
        res.status = ST_INVALID;
        emit_cnt   = '0;
      end
    end

    if (do_acc) begin
      cnt_d = cnt_inc;
      if (!st_i.ovf) begin
        if (acc_ovf) begin
          st_d.ovf = 1'b1;
        end else begin
          st_d.acc = prod[VALUE_W-1:0];
        end
      end
    end

    if (do_finish) begin
      res.emit = 1'b1;
      if (st_i.ovf) begin
        res.value  = (mode_i == MODE_UNSIGNED) ? UMAX : SMAX;
        res.status = ST_RANGE;
      end else begin
        res.value  = st_i.neg ? (VALUE_W'(0) - st_i.acc) : st_i.acc;
        res.status = ST_OK;
      end
    end

    emit_ext     = CW'(emit_cnt);
    res.consumed = (emit_ext > CW'({CONS_W{1'b1}})) ? {CONS_W{1'b1}} :
                   emit_ext[CONS_W-1:0];

    if (res.emit) begin
      st_d  = STATE_RESET;
      cnt_d = '0;
    end
  end

  assign st_o  = st_d;
  assign cnt_o = cnt_d;
  assign res_o = res;

endmodule

FILE: design/ascii_integer_parser_core.sv
// Top level of the streaming ASCII string-to-integer parser.
//
//   channel  | modport | payload                         | transfer
//   ---------+---------+---------------------------------+-------------------
//   in_i     | sink    | ch[7:0]                         | valid && ready
//   out_o    | source  | value[63:0] consumed[15:0] st[1:0]| valid && ready
//   cfg_i    | sink    | index[0:0] data[7:0]            | valid (ready = 1)
//
// One character per cycle unless out_o stalls: input register, one step
// of 64x6 multiply-add with range compare, then the string state and the
// result register. A result passes both registers before it is valid.
// Reset restores radix 10, signed mode and an empty string; no clearing pass.
// A full result register holds the input stage until out_o is taken.
`timescale 1ns / 1ps

module ascii_integer_parser_core import aip_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aip_ch_if.sink     in_i,
  aip_res_if.source  out_o,
  aip_cfg_if.sink    cfg_i
);

  logic                  in_valid_q;
  logic [CH_W-1:0]       in_ch_q;
  logic                  advance;
  parse_state_t          st_q, st_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [MODE_W-1:0]     mode_q;
  parse_result_t         step_res;
  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_value_q;
  logic [CONS_W-1:0]     out_cons_q;
  logic [STATUS_W-1:0]   out_status_q;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  aip_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_aip_step (
    .ch_i    (in_ch_q),
    .radix_i (radix_q),
    .mode_i  (mode_q),
    .st_i    (st_q),
    .cnt_i   (cnt_q),
    .st_o    (st_d),
    .cnt_o   (cnt_d),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      st_q        <= STATE_RESET;
      cnt_q       <= '0;
      radix_q     <= RADIX_RESET;
      mode_q      <= MODE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
      if (advance && step_res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_RADIX: radix_q <= cfg_i.data[RADIX_W-1:0];
          CFG_MODE:  mode_q  <= cfg_i.data[MODE_W-1:0];
          default:   radix_q <= radix_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_ch_q <= in_i.ch;
    end
    if (advance && step_res.emit) begin
      out_value_q  <= step_res.value;
      out_cons_q   <= step_res.consumed;
      out_status_q <= step_res.status;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value    = out_value_q;
  assign out_o.consumed = out_cons_q;
  assign out_o.status   = out_status_q;

endmodule

FILE: design/aip_checker.sv
// Port-level checks on the parser result channel, bound to the top level.
`timescale 1ns / 1ps

module aip_checker import aip_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [VALUE_W-1:0]  out_value_i,
  input logic [CONS_W-1:0]   out_consumed_i,
  input logic [STATUS_W-1:0] out_status_i
);

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_INVALID) |->
      (out_value_i == '0) && (out_consumed_i == '0))
    else $error("invalid result carries nonzero value or count");

  a_range_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_RANGE) |->
      (out_value_i == SMAX) || (out_value_i == UMAX))
    else $error("range result not saturated");

  a_status_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_status_i == ST_OK) || (out_status_i == ST_INVALID) ||
      (out_status_i == ST_RANGE))
    else $error("undefined status code");

endmodule

bind ascii_integer_parser_core aip_checker u_aip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value),
  .out_consumed_i (out_o.consumed),
  .out_status_i   (out_o.status)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the streaming ASCII integer parser core.
`timescale 1ns / 1ps

module tb_top;
  import aip_pkg::*;

  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned ITEMS        = 900;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam longint unsigned TIMEOUT_NS = 2000000;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [CONS_W-1:0]   consumed;
    logic [STATUS_W-1:0] status;
  } num_result_t;

  typedef struct {
    logic [RADIX_W-1:0] radix;
    logic [MODE_W-1:0]  mode;
    string              text;
    logic [CH_W-1:0]    term;
    bit                 fixed;
    num_result_t        res;
  } string_vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aip_ch_if  in_if();
  aip_res_if out_if();
  aip_cfg_if cfg_if();

  ascii_integer_parser_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Parser state mirror
  phase_e                ph;
  logic [VALUE_W-1:0]    acc;
  logic                  neg;
  logic                  ovf;
  logic [RADIX_W-1:0]    base;
  logic [COUNT_BITS-1:0] cnt;
  logic [RADIX_W-1:0]    radix_reg;
  logic [MODE_W-1:0]     mode_reg;

  num_result_t expected_numbers[$];
  string_vec_t directed_strings[$];

  logic        tag_fixed;
  num_result_t tag_res;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;

  function automatic logic [RADIX_W-1:0] char_value(input logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return RADIX_W'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_Z) return RADIX_W'(c - CH_LO_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_Z) return RADIX_W'(c - CH_UP_A + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic logic [MODE_W-1:0] MODE_MODE_PICK();
    return MODE_W'($urandom_range(0, 3));
  endfunction

  function automatic void clear_string();
    ph = PH_LEAD;
    acc = '0;
    neg = 1'b0;
    ovf = 1'b0;
    base = '0;
    cnt = '0;
  endfunction

  function automatic void bump_count();
    if (cnt != '1) cnt = cnt + 1'b1;
  endfunction

  function automatic void add_digit(input logic [RADIX_W-1:0] d);
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] lim;
    b = (base < RADIX_MIN) ? VALUE_W'(2) : VALUE_W'(base);
    bump_count();
    if (!ovf) begin
      if (mode_reg == MODE_SIGNED || mode_reg == MODE_UNSIGNED) begin
        lim = (mode_reg == MODE_UNSIGNED) ? UMAX : (neg ? SMAX_NEG : SMAX);
        if (acc > (lim - VALUE_W'(d)) / b) ovf = 1'b1;
      end
      if (!ovf) acc = acc * b + VALUE_W'(d);
    end
  endfunction

  function automatic num_result_t close_string(input logic [VALUE_W-1:0] v,
                                               input logic [COUNT_BITS-1:0] n,
                                               input logic [STATUS_W-1:0] s);
    num_result_t r;
    r.value = v;
    r.consumed = CONS_W'(n);
    r.status = s;
    clear_string();
    return r;
  endfunction

  function automatic num_result_t end_number();
    if (ovf) return close_string(mode_reg == MODE_UNSIGNED ? UMAX : SMAX, cnt, ST_RANGE);
    return close_string(neg ? (~acc + 1'b1) : acc, cnt, ST_OK);
  endfunction

  function automatic bit start_number(input logic [CH_W-1:0] c,
                                     input logic [RADIX_W-1:0] d,
                                     output num_result_t r);
    logic [RADIX_W-1:0] b;
    r = '0;
    if (radix_reg != RADIX_AUTO && (radix_reg < RADIX_MIN || radix_reg > RADIX_MAX)) begin
      r = close_string('0, '0, ST_INVALID);
      return 1'b1;
    end
    if (c == CH_ZERO && (radix_reg == RADIX_AUTO || radix_reg == BASE_HEX)) begin
      base = (radix_reg == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
      acc = '0;
      bump_count();
      ph = PH_ZERO;
      return 1'b0;
    end
    b = (radix_reg == RADIX_AUTO) ? BASE_DEC : radix_reg;
    if (d < b) begin
      base = b;
      add_digit(d);
      ph = PH_DIGITS;
      return 1'b0;
    end
    r = close_string('0, '0, ST_INVALID);
    return 1'b1;
  endfunction

  function automatic bit parse_char(input logic [CH_W-1:0] c, output num_result_t r);
    logic [RADIX_W-1:0] d;
    d = char_value(c);
    r = '0;
    case (ph)
      PH_FIRST: return start_number(c, d, r);
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          bump_count();
          ph = PH_XSEEN;
          return 1'b0;
        end
        ph = PH_DIGITS;
        if (d < base) begin
          add_digit(d);
          return 1'b0;
        end
        r = end_number();
        return 1'b1;
      end
      PH_XSEEN: begin
        if (d < BASE_HEX) begin
          base = BASE_HEX;
          add_digit(d);
          ph = PH_DIGITS;
          return 1'b0;
        end
        r = close_string('0, (cnt == '0) ? cnt : cnt - 1'b1, ST_OK);
        return 1'b1;
      end
      PH_DIGITS: begin
        if (d < base) begin
          add_digit(d);
          return 1'b0;
        end
        r = end_number();
        return 1'b1;
      end
      default: begin
        ph = PH_LEAD;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          bump_count();
          return 1'b0;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          bump_count();
          ph = PH_FIRST;
          return 1'b0;
        end
        return start_number(c, d, r);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    errors++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    num_result_t want;
    num_result_t r;
    bit          emits;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch("result with nothing pending, value", out_if.value, '0);
        end else begin
          want = expected_numbers.pop_front();
          if (out_if.value !== want.value)
            report_mismatch("value", out_if.value, want.value);
          if (out_if.consumed !== want.consumed)
            report_mismatch("consumed", VALUE_W'(out_if.consumed), VALUE_W'(want.consumed));
          if (out_if.status !== want.status)
            report_mismatch("status", VALUE_W'(out_if.status), VALUE_W'(want.status));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_RADIX) radix_reg = cfg_if.data[RADIX_W-1:0];
        else mode_reg = cfg_if.data[MODE_W-1:0];
      end
      if (in_if.valid && in_if.ready) begin
        emits = parse_char(in_if.ch, r);
        if (tag_fixed) expected_numbers.push_back(tag_res);
        else if (emits) expected_numbers.push_back(r);
      end
    end
  end

  task automatic send_byte(input logic [CH_W-1:0] c, input bit fixed = 1'b0,
                           input num_result_t fres = '0);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch <= c;
    tag_fixed <= fixed;
    tag_res <= fres;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_numbers.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [RADIX_W-1:0] r, input logic [MODE_W-1:0] m);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_RADIX;
    cfg_if.data <= {2'($urandom_range(0, 3)), r};
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.index <= CFG_MODE;
    cfg_if.data <= {6'($urandom_range(0, 63)), m};
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_string();
    int unsigned n;
    int unsigned v;
    int unsigned style;
    bit is_long;
    logic [RADIX_W-1:0] b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      v = $urandom_range(0, 5);
      send_byte(v == 5 ? CH_SPACE : CH_TAB + 8'(v));
    end
    if ($urandom_range(0, 2) == 0) send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    b = (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX) ? radix_reg : BASE_DEC;
    style = $urandom_range(0, 3);
    if (radix_reg == RADIX_AUTO && style < 2) begin
      send_byte(CH_ZERO);
      if (style == 0) begin
        send_byte($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        b = BASE_HEX;
      end else begin
        b = BASE_OCT;
      end
    end else if (radix_reg == BASE_HEX && style == 0) begin
      send_byte(CH_ZERO);
      send_byte($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
    end
    is_long = ($urandom_range(0, 4) == 0);
    n = is_long ? $urandom_range(12, 26) : $urandom_range(0, 6);
    repeat (n) begin
      v = (is_long && $urandom_range(0, 1) != 0) ? b - 1 : $urandom_range(0, b - 1);
      send_byte(v < 10 ? CH_ZERO + 8'(v)
                       : ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(v - 10));
    end
    send_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned w;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      w = calm ? 0 : $urandom_range(0, 6);
      if (w != 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      @(negedge clk_i);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned stop_at;
    int unsigned quota;
    int unsigned phase_no;
    in_if.valid = 1'b0;
    in_if.ch = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_RADIX;
    cfg_if.data = '0;
    tag_fixed = 1'b0;
    tag_res = '0;
    radix_reg = RADIX_RESET;
    mode_reg = MODE_RESET;
    clear_string();

    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "42", CH_SPACE, 1'b1,
                                 '{64'd42, 16'd2, ST_OK}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, " \t\n\v\f\015+9", 8'h2C, 1'b1,
                                 '{64'd9, 16'd8, ST_OK}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "", CH_LO_X, 1'b1,
                                 '{64'd0, 16'd0, ST_INVALID}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "", 8'hFF, 1'b1,
                                 '{64'd0, 16'd0, ST_INVALID}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "+", CH_SPACE, 1'b1,
                                 '{64'd0, 16'd0, ST_INVALID}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "9223372036854775807", 8'h00, 1'b1,
                                 '{SMAX, 16'd19, ST_OK}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "9223372036854775808", 8'hFF, 1'b1,
                                 '{SMAX, 16'd19, ST_RANGE}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "-9223372036854775808", CH_SPACE,
                                 1'b1, '{SMAX_NEG, 16'd20, ST_OK}});
    directed_strings.push_back('{BASE_DEC, MODE_SIGNED, "-9223372036854775809", CH_SPACE,
                                 1'b1, '{SMAX, 16'd20, ST_RANGE}});
    directed_strings.push_back('{BASE_DEC, MODE_UNSIGNED, "18446744073709551615", CH_SPACE,
                                 1'b1, '{UMAX, 16'd20, ST_OK}});
    directed_strings.push_back('{BASE_DEC, MODE_UNSIGNED, "18446744073709551616", CH_SPACE,
                                 1'b1, '{UMAX, 16'd20, ST_RANGE}});
    directed_strings.push_back('{BASE_DEC, MODE_UNSIGNED, "-1", CH_SPACE, 1'b1,
                                 '{UMAX, 16'd2, ST_OK}});
    directed_strings.push_back('{BASE_DEC, MODE_PLAIN, "18446744073709551617", CH_SPACE,
                                 1'b1, '{64'd1, 16'd20, ST_OK}});
    directed_strings.push_back('{BASE_DEC, 2'd3, "-18446744073709551617", CH_SPACE, 1'b1,
                                 '{UMAX, 16'd21, ST_OK}});
    directed_strings.push_back('{RADIX_AUTO, MODE_SIGNED, "0x1F", CH_SPACE, 1'b1,
                                 '{64'd31, 16'd4, ST_OK}});
    directed_strings.push_back('{RADIX_AUTO, MODE_SIGNED, "017", CH_NINE, 1'b1,
                                 '{64'd15, 16'd3, ST_OK}});
    directed_strings.push_back('{RADIX_AUTO, MODE_SIGNED, "0x", 8'h67, 1'b1,
                                 '{64'd0, 16'd1, ST_OK}});
    directed_strings.push_back('{RADIX_AUTO, MODE_SIGNED, "0", CH_SPACE, 1'b1,
                                 '{64'd0, 16'd1, ST_OK}});
    directed_strings.push_back('{BASE_HEX, MODE_SIGNED, "0XfF", CH_SPACE, 1'b1,
                                 '{64'd255, 16'd4, ST_OK}});
    directed_strings.push_back('{RADIX_MIN, MODE_SIGNED, "101", 8'h32, 1'b1,
                                 '{64'd5, 16'd3, ST_OK}});
    directed_strings.push_back('{RADIX_MAX, MODE_SIGNED, "Zz", CH_MINUS, 1'b1,
                                 '{64'd1295, 16'd2, ST_OK}});
    directed_strings.push_back('{RADIX_MAX, MODE_UNSIGNED, "zzzzzzzzzzzzz", CH_SPACE, 1'b1,
                                 '{UMAX, 16'd13, ST_RANGE}});
    directed_strings.push_back('{6'd1, MODE_SIGNED, "", 8'h35, 1'b1,
                                 '{64'd0, 16'd0, ST_INVALID}});
    directed_strings.push_back('{6'd63, MODE_SIGNED, "-", 8'h37, 1'b1,
                                 '{64'd0, 16'd0, ST_INVALID}});
    directed_strings.push_back('{BASE_OCT, MODE_PLAIN, " -777", 8'h38, 1'b0, '0});

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_strings[i]) begin
      if (directed_strings[i].radix != radix_reg || directed_strings[i].mode != mode_reg) begin
        drain();
        set_config(directed_strings[i].radix, directed_strings[i].mode);
      end
      for (int k = 0; k < directed_strings[i].text.len(); k++)
        send_byte(directed_strings[i].text[k]);
      send_byte(directed_strings[i].term, directed_strings[i].fixed, directed_strings[i].res);
    end

    phase_no = 0;
    stop_at = items_sent + ITEMS;
    while (items_sent < stop_at) begin
      drain();
      case ($urandom_range(0, 9))
        0, 1:    set_config(RADIX_AUTO, MODE_MODE_PICK());
        2:       set_config(BASE_HEX, MODE_MODE_PICK());
        3:       set_config(6'($urandom_range(0, 63)), MODE_MODE_PICK());
        default: set_config(6'($urandom_range(2, 36)), MODE_MODE_PICK());
      endcase
      calm = (phase_no % 7 == 5);
      if (phase_no == 2) hold_req = 1'b1;
      quota = items_sent + $urandom_range(40, 120);
      while (items_sent < quota) send_random_string();
      phase_no++;
    end
    calm = 1'b0;

    drain();
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
